// File: rtl/core/ldf_pkg.sv
package ldf_pkg;

   localparam int PKT_LEN  = 22;
   localparam int PTR_W    = 5;
   localparam int ACC_W    = 26;
   localparam int CHK_W    = 15;
   localparam int CSR_IDX_W = 1;

   // byte positions inside a packet
   localparam logic [PTR_W-1:0] POS_INDEX    = 5'd1;
   localparam logic [PTR_W-1:0] POS_SPEED_LO = 5'd2;
   localparam logic [PTR_W-1:0] POS_SPEED_HI = 5'd3;
   localparam logic [PTR_W-1:0] POS_LAST_RD  = 5'd19;
   localparam logic [PTR_W-1:0] POS_CHK_HI   = 5'd21;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_BYTE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_BASE = 1'd1;

   localparam logic [7:0] START_BYTE_RST = 8'd250;
   localparam logic [7:0] INDEX_BASE_RST = 8'd160;

   // byte lanes of one 4-byte reading
   typedef enum logic [1:0] {
      LANE_DIST_LO = 2'd0,
      LANE_DIST_HI = 2'd1,
      LANE_STR_LO  = 2'd2,
      LANE_STR_HI  = 2'd3
   } lane_type;

   // grouped emission status between the sequencer and the result register
   typedef struct packed {
      logic consume;
      logic final_byte;
      logic out_free;
   } emit_ctl_type;

endpackage

// File: rtl/core/ldf_ram.sv
module ldf_ram #(
   parameter int Width = 8,
   parameter int Depth = 22
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold read data until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/lidar_packet_deframer_top.sv
// Lidar packet deframer.
// Request channel (req_valid/req_ready/req_rx_byte) carries one serial byte
// per request. The block hunts for the start byte, then collects a 22-byte
// packet into a small packet RAM while it folds the checksum on the fly.
// Bytes are taken one per cycle while a packet is collected.
// When the checksum of a complete packet matches, the block reads the
// packet back from the RAM, one byte per cycle unless a result waits for
// the receiver, and emits four results on the rsp_ channel (angle,
// distance, strength, flags, speed, last mark). Each result is formed once
// the last byte of its reading is read back. During this readback
// req_ready is low. A bad packet is dropped silently and does not stall
// requests.
// A stalled receiver holds the result register; the readback pauses
// behind it, and new bytes are taken again once the readback is done even
// if the last result still waits.
// Configuration (csr_wr_en/csr_index/csr_wdata) sets the start byte and the
// index base; write it only while idle. Reset returns to hunting, loads the
// default start byte 250 and index base 160, and empties the result slot.
module lidar_packet_deframer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_angle,
   output logic [13:0] rsp_distance,
   output logic [15:0] rsp_strength,
   output logic        rsp_is_valid,
   output logic        rsp_is_strong,
   output logic [15:0] rsp_speed_raw,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [ldf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]  csr_wdata
);

   // configuration
   logic [7:0] start_byte_ff;
   logic [7:0] index_base_ff;

   // frame collection
   logic                        in_packet_ff, in_packet_in;
   logic [ldf_pkg::PTR_W-1:0]   byte_count_ff, byte_count_in;
   logic [ldf_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic [7:0]                  low_hold_ff, low_hold_in;
   logic                        req_accept;
   logic                        emit_start;
   logic [ldf_pkg::ACC_W-1:0]   acc_step;
   logic [15:0]                 fold_sum;
   logic [ldf_pkg::CHK_W-1:0]   chk;
   logic                        chk_ok;

   // packet RAM ports
   logic                        ram_wr_en;
   logic [ldf_pkg::PTR_W-1:0]   ram_wr_addr;
   logic                        ram_rd_en;
   logic [7:0]                  ram_rd_data;

   // readback sequencer
   logic                        emit_busy_ff;
   logic [ldf_pkg::PTR_W-1:0]   iss_addr_ff;
   logic                        iss_done_ff;
   logic                        pend_ff;
   logic [ldf_pkg::PTR_W-1:0]   pend_addr_ff;
   ldf_pkg::emit_ctl_type       ctl;
   ldf_pkg::lane_type           lane;
   logic [1:0]                  rd_num;
   logic                        bad;

   // fields gathered during readback
   logic [15:0] group_ff;
   logic [15:0] speed_ff;
   logic [7:0]  dist_lo_ff;
   logic [7:0]  dist_hi_ff;
   logic [7:0]  str_lo_ff;

   // result register
   logic        rsp_valid_ff;
   logic [15:0] rsp_angle_ff;
   logic [13:0] rsp_distance_ff;
   logic [15:0] rsp_strength_ff;
   logic        rsp_is_valid_ff;
   logic        rsp_is_strong_ff;
   logic [15:0] rsp_speed_raw_ff;
   logic        rsp_last_ff;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= ldf_pkg::START_BYTE_RST;
         index_base_ff <= ldf_pkg::INDEX_BASE_RST;
      end else if (csr_wr_en) begin
         if (csr_index == ldf_pkg::CSR_START_BYTE) begin
            start_byte_ff <= csr_wdata;
         end
         if (csr_index == ldf_pkg::CSR_INDEX_BASE) begin
            index_base_ff <= csr_wdata;
         end
      end
   end

   // ------------------------------------------------------------------
   // Frame collection and running checksum
   // ------------------------------------------------------------------
   // Stall requests while the packet RAM is read back.
   assign req_ready  = !emit_busy_ff;
   assign req_accept = req_valid && req_ready;

   // chk = chk*2 + little-endian word, kept to 26 bits
   assign acc_step = {acc_ff[ldf_pkg::ACC_W-2:0], 1'b0}
                   + {{(ldf_pkg::ACC_W-16){1'b0}}, req_rx_byte, low_hold_ff};
   // fold the upper bits back into the low 15
   assign fold_sum = {1'b0, acc_ff[ldf_pkg::CHK_W-1:0]}
                   + {5'b0, acc_ff[ldf_pkg::ACC_W-1:ldf_pkg::CHK_W]};
   assign chk      = fold_sum[ldf_pkg::CHK_W-1:0];
   // low checksum byte sits in low_hold_ff, high byte is arriving now
   assign chk_ok   = (chk[7:0] == low_hold_ff) && ({1'b0, chk[14:8]} == req_rx_byte);

   assign ram_wr_en   = req_accept && (in_packet_ff || (req_rx_byte == start_byte_ff));
   assign ram_wr_addr = in_packet_ff ? byte_count_ff : '0;

   always_comb begin
      in_packet_in  = in_packet_ff;
      byte_count_in = byte_count_ff;
      acc_in        = acc_ff;
      low_hold_in   = low_hold_ff;
      emit_start    = 1'b0;
      if (req_accept) begin
         if (!in_packet_ff) begin
            // open a packet on the start byte, drop anything else
            if (req_rx_byte == start_byte_ff) begin
               in_packet_in  = 1'b1;
               byte_count_in = 5'd1;
               acc_in        = '0;
               low_hold_in   = req_rx_byte;
            end
         end else if (byte_count_ff == ldf_pkg::POS_CHK_HI) begin
            // packet complete: check and return to hunting
            emit_start    = chk_ok;
            in_packet_in  = 1'b0;
            byte_count_in = '0;
            acc_in        = '0;
            low_hold_in   = '0;
         end else begin
            byte_count_in = byte_count_ff + 5'd1;
            if (!byte_count_ff[0]) begin
               low_hold_in = req_rx_byte;
            end else begin
               acc_in = acc_step;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_packet_ff  <= 1'b0;
         byte_count_ff <= '0;
         acc_ff        <= '0;
         low_hold_ff   <= '0;
      end else begin
         in_packet_ff  <= in_packet_in;
         byte_count_ff <= byte_count_in;
         acc_ff        <= acc_in;
         low_hold_ff   <= low_hold_in;
      end
   end

   // ------------------------------------------------------------------
   // Packet RAM
   // ------------------------------------------------------------------
   ldf_ram #(
      .Width (8),
      .Depth (ldf_pkg::PKT_LEN)
   ) u_pkt_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_rx_byte),
      .rd_en   (ram_rd_en),
      .rd_addr (iss_addr_ff),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------------------------------
   // Readback sequencer: issue addresses 1..19, one read in flight.
   // The RAM holds its read data until the byte is consumed; the last
   // byte of a reading waits for a free result slot.
   // ------------------------------------------------------------------
   assign lane           = ldf_pkg::lane_type'(pend_addr_ff[1:0]);
   assign ctl.final_byte = (lane == ldf_pkg::LANE_STR_HI) && (pend_addr_ff[4:2] != 3'd0);
   assign ctl.out_free   = !rsp_valid_ff || rsp_ready;
   assign ctl.consume    = pend_ff && (!ctl.final_byte || ctl.out_free);
   assign ram_rd_en      = emit_busy_ff && !iss_done_ff && (!pend_ff || ctl.consume);

   // reading number 0..3 from the byte address (4..7 -> 0, ..., 16..19 -> 3)
   assign rd_num = pend_addr_ff[3:2] - 2'd1;
   assign bad    = dist_hi_ff[7] || dist_hi_ff[6];

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_busy_ff <= 1'b0;
         iss_addr_ff  <= ldf_pkg::POS_INDEX;
         iss_done_ff  <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         if (emit_start) begin
            emit_busy_ff <= 1'b1;
            iss_addr_ff  <= ldf_pkg::POS_INDEX;
            iss_done_ff  <= 1'b0;
         end else begin
            if (ctl.consume && (pend_addr_ff == ldf_pkg::POS_LAST_RD)) begin
               emit_busy_ff <= 1'b0;
            end
            if (ram_rd_en) begin
               iss_addr_ff <= iss_addr_ff + 5'd1;
               if (iss_addr_ff == ldf_pkg::POS_LAST_RD) begin
                  iss_done_ff <= 1'b1;
               end
            end
         end
         if (ram_rd_en) begin
            pend_ff <= 1'b1;
         end else if (ctl.consume) begin
            pend_ff <= 1'b0;
         end
      end
   end

   // gather packet fields as bytes come back
   always_ff @(posedge clock) begin
      if (ram_rd_en) begin
         pend_addr_ff <= iss_addr_ff;
      end
      if (ctl.consume) begin
         case (pend_addr_ff)
            ldf_pkg::POS_INDEX: begin
               group_ff <= ({8'd0, ram_rd_data} - {8'd0, index_base_ff}) << 2;
            end
            ldf_pkg::POS_SPEED_LO: begin
               speed_ff[7:0] <= ram_rd_data;
            end
            ldf_pkg::POS_SPEED_HI: begin
               speed_ff[15:8] <= ram_rd_data;
            end
            default: begin
               case (lane)
                  ldf_pkg::LANE_DIST_LO: dist_lo_ff <= ram_rd_data;
                  ldf_pkg::LANE_DIST_HI: dist_hi_ff <= ram_rd_data;
                  ldf_pkg::LANE_STR_LO:  str_lo_ff  <= ram_rd_data;
                  default: ;
               endcase
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Result register
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.consume && ctl.final_byte) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.consume && ctl.final_byte) begin
         rsp_angle_ff     <= group_ff + {14'd0, rd_num};
         // drop distance and strength when either flag is set
         rsp_distance_ff  <= bad ? 14'd0 : {dist_hi_ff[5:0], dist_lo_ff};
         rsp_strength_ff  <= bad ? 16'd0 : {ram_rd_data, str_lo_ff};
         rsp_is_valid_ff  <= !dist_hi_ff[7];
         rsp_is_strong_ff <= !dist_hi_ff[6];
         rsp_speed_raw_ff <= speed_ff;
         rsp_last_ff      <= (pend_addr_ff == ldf_pkg::POS_LAST_RD);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_angle     = rsp_angle_ff;
   assign rsp_distance  = rsp_distance_ff;
   assign rsp_strength  = rsp_strength_ff;
   assign rsp_is_valid  = rsp_is_valid_ff;
   assign rsp_is_strong = rsp_is_strong_ff;
   assign rsp_speed_raw = rsp_speed_raw_ff;
   assign rsp_last      = rsp_last_ff;

`ifndef SYNTHESIS
   // no packet byte may land in the RAM while it is read back
   a_no_write_in_readback: assert property (@(posedge clock) disable iff (reset)
      emit_busy_ff |-> !ram_wr_en)
      else $error("packet RAM written during readback");

   // the byte counter stays inside the packet and is zero while hunting
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (in_packet_ff && (byte_count_ff <= ldf_pkg::POS_CHK_HI))
      || (!in_packet_ff && (byte_count_ff == '0)))
      else $error("byte counter out of range");

   // a pending read never points outside the readback window
   a_pend_addr: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> ((pend_addr_ff >= ldf_pkg::POS_INDEX)
                   && (pend_addr_ff <= ldf_pkg::POS_LAST_RD)))
      else $error("pending read address outside packet readings");

   // a new read never overwrites a byte that was not consumed
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      ram_rd_en |-> (!pend_ff || ctl.consume))
      else $error("read data overwritten before use");

   // the readback ends together with the last result of the packet
   a_last_ends_readback: assert property (@(posedge clock) disable iff (reset)
      (ctl.consume && ctl.final_byte && (pend_addr_ff == ldf_pkg::POS_LAST_RD))
      |=> (rsp_valid_ff && rsp_last_ff && !emit_busy_ff))
      else $error("last result not aligned with end of readback");
`endif

endmodule

// File: tb/lidar_packet_deframer_top_test.sv
module lidar_packet_deframer_top_test;

   // Upper bound on the whole run; the slowest correct run is far below it.
   localparam int CYCLE_LIMIT   = 200000;
   // Quiet cycles after the last result before a register write or the end:
   // covers the readback of a packet with margin.
   localparam int SETTLE_CYCLES = 40;
   // Packet bytes per random phase; stray noise bytes do not count.
   localparam int PHASE_BYTES   = 20;
   localparam int PHASES        = 6;

   typedef enum logic [1:0] {CHK_GOOD, CHK_FLIP, CHK_HI7} chk_mode_type;

   // One measurement point as it leaves the block.
   typedef struct packed {
      logic [15:0] angle;
      logic [13:0] distance;
      logic [15:0] strength;
      logic        is_valid;
      logic        is_strong;
      logic [15:0] speed_raw;
      logic        last;
   } scan_point_type;

   // One directed packet. All four readings use the same four bytes, so the
   // typed-in point applies to every reading with angle stepping by one.
   typedef struct packed {
      logic [3:0]   noise;
      logic [7:0]   index;
      logic [15:0]  speed;
      logic [7:0]   d_lo;
      logic [7:0]   d_hi;
      logic [7:0]   s_lo;
      logic [7:0]   s_hi;
      chk_mode_type chk;
      logic         typed;
      logic [15:0]  t_angle;
      logic [13:0]  t_dist;
      logic [15:0]  t_str;
      logic         t_valid;
      logic         t_strong;
   } shot_row_type;

   // Directed packets, sent with the reset values of the registers
   // (start byte 250, index base 160).
   localparam int SHOTS = 10;
   shot_row_type shot_table [SHOTS] = '{
      // plain reading right after reset, index equal to the base
      '{4'd0, 8'd160, 16'h1234, 8'h34, 8'h12, 8'h78, 8'h56, CHK_GOOD,
        1'b1, 16'd0, 14'h1234, 16'h5678, 1'b1, 1'b1},
      // all fields at their maximum
      '{4'd0, 8'd255, 16'hFFFF, 8'hFF, 8'h3F, 8'hFF, 8'hFF, CHK_GOOD,
        1'b1, 16'd380, 14'h3FFF, 16'hFFFF, 1'b1, 1'b1},
      // all zero, index below the base wraps the angle
      '{4'd0, 8'd0, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, CHK_GOOD,
        1'b1, 16'd64896, 14'h0000, 16'h0000, 1'b1, 1'b1},
      // invalid-data flag only, after a little noise
      '{4'd2, 8'd161, 16'h0C80, 8'h21, 8'h95, 8'h43, 8'h01, CHK_GOOD,
        1'b1, 16'd4, 14'h0000, 16'h0000, 1'b0, 1'b1},
      // strength-warning flag only
      '{4'd0, 8'd162, 16'h0C80, 8'h21, 8'h55, 8'h43, 8'h01, CHK_GOOD,
        1'b1, 16'd8, 14'h0000, 16'h0000, 1'b1, 1'b0},
      // both flags
      '{4'd0, 8'd163, 16'h0C80, 8'h21, 8'hFF, 8'h43, 8'h01, CHK_GOOD,
        1'b1, 16'd12, 14'h0000, 16'h0000, 1'b0, 1'b0},
      // corrupted checksum low byte: dropped
      '{4'd0, 8'd170, 16'h2A00, 8'h10, 8'h02, 8'h20, 8'h00, CHK_FLIP,
        1'b0, 16'd0, 14'h0000, 16'h0000, 1'b0, 1'b0},
      // checksum high byte with bit 7 set: can never match
      '{4'd0, 8'd171, 16'h2A00, 8'h10, 8'h02, 8'h20, 8'h00, CHK_HI7,
        1'b0, 16'd0, 14'h0000, 16'h0000, 1'b0, 1'b0},
      // start byte value all over the packet body
      '{4'd3, 8'd250, 16'hFAFA, 8'hFA, 8'hFA, 8'hFA, 8'hFA, CHK_GOOD,
        1'b0, 16'd0, 14'h0000, 16'h0000, 1'b0, 1'b0},
      // ordinary packet behind a longer run of noise
      '{4'd5, 8'd200, 16'h4B3C, 8'h7E, 8'h2D, 8'hC3, 8'h81, CHK_GOOD,
        1'b0, 16'd0, 14'h0000, 16'h0000, 1'b0, 1'b0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b1;
   logic [15:0] rsp_angle;
   logic [13:0] rsp_distance;
   logic [15:0] rsp_strength;
   logic        rsp_is_valid;
   logic        rsp_is_strong;
   logic [15:0] rsp_speed_raw;
   logic        rsp_last;
   logic        csr_wr_en = 1'b0;
   logic [ldf_pkg::CSR_IDX_W-1:0] csr_index = ldf_pkg::CSR_START_BYTE;
   logic [7:0]  csr_wdata = 8'h00;

   // Deframer mirror: registers, hunt/collect state and the packet bytes.
   logic [7:0]  cfg_start = ldf_pkg::START_BYTE_RST;
   logic [7:0]  cfg_base  = ldf_pkg::INDEX_BASE_RST;
   logic        in_frame  = 1'b0;
   int unsigned frame_pos = 0;
   logic [7:0]  frame_bytes [ldf_pkg::PKT_LEN];

   // Points the block still owes, oldest first.
   scan_point_type scan_points [$];

   int unsigned fail_count  = 0;
   int unsigned cycle_count = 0;
   int unsigned stall_left  = 0;
   bit          gaps_on     = 1'b1;
   bit          stalls_on   = 1'b1;

   lidar_packet_deframer_top uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_rx_byte   (req_rx_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_angle     (rsp_angle),
      .rsp_distance  (rsp_distance),
      .rsp_strength  (rsp_strength),
      .rsp_is_valid  (rsp_is_valid),
      .rsp_is_strong (rsp_is_strong),
      .rsp_speed_raw (rsp_speed_raw),
      .rsp_last      (rsp_last),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial forever #5 clock = ~clock;

   // Give up on a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      fail_count++;
   endtask

   // Checksum over the ten little-endian words in bytes 0..19: shift-add
   // into a 26-bit sum, then fold the upper bits back into 15.
   function automatic logic [14:0] fold_checksum(input logic [7:0] pkt [ldf_pkg::PKT_LEN]);
      logic [25:0] acc;
      acc = '0;
      for (int w = 0; w < 10; w++)
         acc = (acc << 1) + {10'b0, pkt[2*w+1], pkt[2*w]};
      return acc[14:0] + 15'(acc[25:15]);
   endfunction

   // Advance the deframer mirror by one accepted byte and queue the four
   // points of a packet whose checksum holds.
   function automatic void deframe_byte(input logic [7:0] b);
      logic [14:0]    chk;
      logic [15:0]    group;
      logic [7:0]     dm;
      logic           flagged;
      scan_point_type pt;
      // hunting: drop everything but the start byte
      if (!in_frame && b != cfg_start) return;
      in_frame = 1'b1;
      frame_bytes[frame_pos] = b;
      frame_pos++;
      if (frame_pos < ldf_pkg::PKT_LEN) return;
      in_frame  = 1'b0;
      frame_pos = 0;
      chk = fold_checksum(frame_bytes);
      // high byte with bit 7 set never matches the 15-bit checksum
      if ({1'b0, chk} != {frame_bytes[ldf_pkg::POS_CHK_HI],
                          frame_bytes[ldf_pkg::POS_CHK_HI-1]}) return;
      // index below the base wraps before the times four
      group = (16'(frame_bytes[ldf_pkg::POS_INDEX]) - 16'(cfg_base)) << 2;
      for (int k = 0; k < 4; k++) begin
         dm      = frame_bytes[4*k + 4 + ldf_pkg::LANE_DIST_HI];
         flagged = dm[7] | dm[6];
         pt.angle     = group + 16'(k);
         pt.distance  = flagged ? 14'h0
                                : {dm[5:0], frame_bytes[4*k + 4 + ldf_pkg::LANE_DIST_LO]};
         pt.strength  = flagged ? 16'h0 : {frame_bytes[4*k + 4 + ldf_pkg::LANE_STR_HI],
                                           frame_bytes[4*k + 4 + ldf_pkg::LANE_STR_LO]};
         pt.is_valid  = !dm[7];
         pt.is_strong = !dm[6];
         pt.speed_raw = {frame_bytes[ldf_pkg::POS_SPEED_HI],
                         frame_bytes[ldf_pkg::POS_SPEED_LO]};
         pt.last      = (k == 3);
         scan_points.push_back(pt);
      end
   endfunction

   // Lay out a packet for the current start byte; reads[k] holds
   // {strength hi, strength lo, distance hi, distance lo}.
   function automatic void build_packet(input logic [7:0] index, input logic [15:0] speed,
                                        input logic [31:0] reads [4],
                                        input chk_mode_type mode,
                                        output logic [7:0] pkt [ldf_pkg::PKT_LEN]);
      logic [14:0] chk;
      pkt[0]                     = cfg_start;
      pkt[ldf_pkg::POS_INDEX]    = index;
      pkt[ldf_pkg::POS_SPEED_LO] = speed[7:0];
      pkt[ldf_pkg::POS_SPEED_HI] = speed[15:8];
      for (int k = 0; k < 4; k++)
         for (int j = 0; j < 4; j++)
            pkt[4*k + 4 + j] = reads[k][8*j +: 8];
      pkt[20] = 8'h00;
      pkt[21] = 8'h00;
      chk = fold_checksum(pkt);
      pkt[20] = chk[7:0];
      pkt[21] = {1'b0, chk[14:8]};
      if (mode == CHK_FLIP) pkt[20] = pkt[20] ^ 8'($urandom_range(1, 255));
      if (mode == CHK_HI7)  pkt[21][7] = 1'b1;
   endfunction

   // Any byte but the current start byte.
   function automatic logic [7:0] noise_byte();
      return cfg_start + 8'($urandom_range(1, 255));
   endfunction

   // Offer one request, optionally after an idle burst; hold valid and data
   // until the block takes it, then advance the mirror. Valid is left high
   // so back-to-back requests need no second assignment in one step.
   task automatic send_byte(input logic [7:0] b);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      deframe_byte(b);
   endtask

   // Bring the block back to idle: finish any open frame with filler,
   // drop valid, drain every owed point and let the readback wind down.
   task automatic settle();
      while (in_frame) send_byte(8'($urandom_range(0, 255)));
      req_valid <= 1'b0;
      while (scan_points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both registers on consecutive edges, keeping the enable high.
   task automatic set_mode(input logic [7:0] start, input logic [7:0] base);
      csr_wr_en <= 1'b1;
      csr_index <= ldf_pkg::CSR_START_BYTE;
      csr_wdata <= start;
      @(posedge clock);
      csr_index <= ldf_pkg::CSR_INDEX_BASE;
      csr_wdata <= base;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_start = start;
      cfg_base  = base;
   endtask

   // Mostly whole packets with random content and some bad checksums;
   // the rest is noise bursts and packets cut short.
   task automatic random_phase(input int unsigned goal);
      logic [7:0]   pkt [ldf_pkg::PKT_LEN];
      logic [31:0]  reads [4];
      int unsigned  sent;
      int unsigned  pick;
      int unsigned  cut;
      chk_mode_type mode;
      sent = 0;
      while (sent < goal) begin
         pick = $urandom_range(0, 19);
         if (pick < 3) begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
         end else begin
            for (int k = 0; k < 4; k++) begin
               reads[k] = $urandom;
               // keep most readings clean so the distance path gets exercised
               if ($urandom_range(0, 3) != 0) reads[k][15:14] = 2'b00;
            end
            if (pick < 5)      mode = CHK_FLIP;
            else if (pick < 7) mode = CHK_HI7;
            else               mode = CHK_GOOD;
            build_packet(8'($urandom_range(0, 255)), 16'($urandom), reads, mode, pkt);
            cut = (pick >= 7 && pick < 9) ? $urandom_range(1, ldf_pkg::PKT_LEN - 1)
                                          : ldf_pkg::PKT_LEN;
            for (int i = 0; i < cut; i++) send_byte(pkt[i]);
            sent += cut;
         end
      end
   endtask

   // Receiver: drop ready in random bursts while stalls are enabled.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= (stall_left == 1);
      end else if (stalls_on && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(1, 11);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare every accepted point with the oldest one owed.
   always @(posedge clock) begin : check_points
      scan_point_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (scan_points.size() == 0) begin
            report_mismatch($sformatf("point with none owed, angle %0d", rsp_angle));
         end else begin
            want = scan_points.pop_front();
            if (rsp_angle !== want.angle)
               report_mismatch($sformatf("angle %0d, want %0d", rsp_angle, want.angle));
            if (rsp_distance !== want.distance)
               report_mismatch($sformatf("distance %h, want %h", rsp_distance, want.distance));
            if (rsp_strength !== want.strength)
               report_mismatch($sformatf("strength %h, want %h", rsp_strength, want.strength));
            if (rsp_is_valid !== want.is_valid)
               report_mismatch($sformatf("is_valid %b, want %b", rsp_is_valid, want.is_valid));
            if (rsp_is_strong !== want.is_strong)
               report_mismatch($sformatf("is_strong %b, want %b",
                                         rsp_is_strong, want.is_strong));
            if (rsp_speed_raw !== want.speed_raw)
               report_mismatch($sformatf("speed %h, want %h", rsp_speed_raw, want.speed_raw));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("last %b, want %b", rsp_last, want.last));
         end
      end
   end

   initial begin
      shot_row_type   row;
      logic [7:0]     pkt [ldf_pkg::PKT_LEN];
      logic [31:0]    reads [4];
      scan_point_type pt;
      int unsigned    tail;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed packets with the reset register values. Rows with a
      // typed-in point replace the mirror's points for that packet.
      foreach (shot_table[r]) begin
         row = shot_table[r];
         repeat (row.noise) send_byte(noise_byte());
         for (int k = 0; k < 4; k++) reads[k] = {row.s_hi, row.s_lo, row.d_hi, row.d_lo};
         build_packet(row.index, row.speed, reads, row.chk, pkt);
         for (int i = 0; i < ldf_pkg::PKT_LEN; i++) send_byte(pkt[i]);
         if (row.typed) begin
            if (scan_points.size() < 4) begin
               report_mismatch($sformatf("directed packet %0d yields no points", r));
            end else begin
               tail = scan_points.size() - 4;
               for (int k = 0; k < 4; k++) begin
                  pt = '{row.t_angle + 16'(k), row.t_dist, row.t_str, row.t_valid,
                         row.t_strong, row.speed, k == 3};
                  scan_points[tail + k] = pt;
               end
            end
         end
      end
      settle();

      // Random phases, each under its own register setting: both extremes
      // first, random ones next, the reset values last with no idling.
      for (int p = 0; p < PHASES; p++) begin
         stalls_on = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
         gaps_on   = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
         case (p)
            0:          set_mode(8'h00, 8'h00);
            1:          set_mode(8'hFF, 8'hFF);
            PHASES - 1: set_mode(ldf_pkg::START_BYTE_RST, ldf_pkg::INDEX_BASE_RST);
            default:    set_mode(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         endcase
         random_phase(PHASE_BYTES);
         settle();
      end

      if (fail_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
